// File: src/mpu_region_table_lookup_assert.svh
// ----------------------------------------------------------------------------
// mpu region table lookup assertion macros
// concurrent checks clocked on clk_i and disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef MPU_REGION_TABLE_LOOKUP_ASSERT_SVH
`define MPU_REGION_TABLE_LOOKUP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define MRT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mpu region table check failed");

// consequent must hold in the cycle after the antecedent
`define MRT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mpu region table check failed");

`endif

// File: src/mpu_rtl_pkg.sv
// ----------------------------------------------------------------------------
// mpu_rtl_pkg
// request and register codes plus the transaction record that moves down
// the region cell chain
// ----------------------------------------------------------------------------
package mpu_rtl_pkg;

  localparam int unsigned IdxW  = 4;
  localparam int unsigned WordW = 32;
  localparam int unsigned RnrW  = 8;

  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_READ   = 2'd1,
    REQ_LOOKUP = 2'd2
  } req_type_e;

  typedef enum logic [2:0] {
    SEL_CONTROL = 3'd0,
    SEL_TYPE    = 3'd1,
    SEL_RNR     = 3'd2,
    SEL_BASE    = 3'd3,
    SEL_LIMIT   = 3'd4,
    SEL_ATTR0   = 3'd5,
    SEL_ATTR1   = 3'd6
  } reg_sel_e;

  typedef struct packed {
    logic             vld;
    logic [1:0]       req;
    logic [2:0]       sel;
    logic [WordW-1:0] data;
    logic [WordW-1:0] addr;
    logic [RnrW-1:0]  rnr;
    logic [WordW-1:0] rdata;
    logic             hit;
    logic [IdxW-1:0]  idx;
  } mpu_item_t;

endpackage

// File: src/mpu_rtl_cell.sv
// ----------------------------------------------------------------------------
// mpu_rtl_cell
// one region slot: holds base and limit words, serves base/limit accesses
// for its own region number and matches lookups not yet hit upstream
// ----------------------------------------------------------------------------
module mpu_rtl_cell #(
  parameter int unsigned CellIdx = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  mpu_rtl_pkg::mpu_item_t item_i,
  output mpu_rtl_pkg::mpu_item_t item_o
);
  import mpu_rtl_pkg::*;

  logic [WordW-1:0] base_q, base_d;
  logic [WordW-1:0] limit_q, limit_d;
  logic             vld_q;
  mpu_item_t        pay_q, pay_d;
  logic             own;
  logic             match;
  logic [WordW-1:0] lo_addr, hi_addr;

  assign own     = (item_i.rnr == RnrW'(CellIdx));
  assign lo_addr = {base_q[WordW-1:5], 5'b00000};
  assign hi_addr = {limit_q[WordW-1:5], 5'b11111};
  assign match   = limit_q[0] && (item_i.addr >= lo_addr) && (item_i.addr <= hi_addr);

  always_comb begin
    pay_d   = item_i;
    base_d  = base_q;
    limit_d = limit_q;
    if (item_i.req == REQ_WRITE && own && item_i.vld && adv_i) begin
      case (item_i.sel)
        SEL_BASE:  base_d  = item_i.data;
        SEL_LIMIT: limit_d = item_i.data;
        default:   ;
      endcase
    end
    if (item_i.req == REQ_READ && own) begin
      case (item_i.sel)
        SEL_BASE:  pay_d.rdata = base_q;
        SEL_LIMIT: pay_d.rdata = limit_q;
        default:   ;
      endcase
    end
    if (item_i.req == REQ_LOOKUP && !item_i.hit && match) begin
      pay_d.hit = 1'b1;
      pay_d.idx = IdxW'(CellIdx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      limit_q <= '0;
      vld_q   <= 1'b0;
    end else begin
      base_q  <= base_d;
      limit_q <= limit_d;
      if (adv_i) begin
        vld_q <= item_i.vld;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pay_q <= pay_d;
    end
  end

  always_comb begin
    item_o     = pay_q;
    item_o.vld = vld_q;
  end

endmodule

// File: src/mpu_region_table_lookup.sv
// ----------------------------------------------------------------------------
// mpu_region_table_lookup
// an accepted transaction passes through every region cell register in chain order before its result is valid
// throughput: one transaction per cycle while the output is not stalled, one region cell per pipeline step
// the chain stalls as a whole while the output transaction is stalled
// reset: all region slots, control, region number and attributes clear
// ----------------------------------------------------------------------------
module mpu_region_table_lookup #(
  parameter int unsigned RegionCount = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [2:0]  reg_select_i,
  input  logic [31:0] write_data_i,
  input  logic [31:0] lookup_addr_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] read_data_o,
  output logic        region_hit_o,
  output logic [3:0]  region_index_o
);
  import mpu_rtl_pkg::*;

  localparam logic [WordW-1:0] TypeWord = {16'h0000, 8'(RegionCount), 8'h00};

  logic             adv;
  logic             in_acc;
  logic [2:0]       ctrl_q;
  logic [RnrW-1:0]  rnr_q;
  logic [WordW-1:0] attr0_q, attr1_q;
  mpu_item_t        head;
  mpu_item_t        chain [RegionCount+1];

  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;
  assign in_acc     = in_valid_i && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q  <= '0;
      rnr_q   <= '0;
      attr0_q <= '0;
      attr1_q <= '0;
    end else if (in_acc && req_type_i == REQ_WRITE) begin
      case (reg_select_i)
        SEL_CONTROL: ctrl_q  <= write_data_i[2:0];
        SEL_RNR:     rnr_q   <= write_data_i[RnrW-1:0];
        SEL_ATTR0:   attr0_q <= write_data_i;
        SEL_ATTR1:   attr1_q <= write_data_i;
        default:     ;
      endcase
    end
  end

  always_comb begin
    head.vld   = in_valid_i;
    head.req   = req_type_i;
    head.sel   = reg_select_i;
    head.data  = write_data_i;
    head.addr  = lookup_addr_i;
    head.rnr   = rnr_q;
    head.rdata = '0;
    head.hit   = 1'b0;
    head.idx   = '0;
    if (req_type_i == REQ_READ) begin
      unique case (reg_select_i)
        SEL_CONTROL: head.rdata = {29'b0, ctrl_q};
        SEL_TYPE:    head.rdata = TypeWord;
        SEL_RNR:     head.rdata = {24'b0, rnr_q};
        SEL_ATTR0:   head.rdata = attr0_q;
        SEL_ATTR1:   head.rdata = attr1_q;
        default:     head.rdata = '0;
      endcase
    end
  end

  assign chain[0] = head;

  for (genvar g = 0; g < RegionCount; g++) begin : g_cell
    mpu_rtl_cell #(
      .CellIdx(g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .item_i (chain[g]),
      .item_o (chain[g+1])
    );
  end

  assign out_valid_o    = chain[RegionCount].vld;
  assign read_data_o    = chain[RegionCount].rdata;
  assign region_hit_o   = chain[RegionCount].hit;
  assign region_index_o = chain[RegionCount].idx;

`include "mpu_region_table_lookup_assert.svh"

  `MRT_ASSERT_SAME(a_idx_zero_on_miss, out_valid_o && !region_hit_o, region_index_o == '0)
  `MRT_ASSERT_SAME(a_no_data_on_hit, out_valid_o && region_hit_o, read_data_o == '0)
  `MRT_ASSERT_SAME(a_idx_in_range, out_valid_o && region_hit_o,
                   {1'b0, region_index_o} < 5'(RegionCount))
  `MRT_ASSERT_NEXT(a_rnr_update,
                   in_acc && req_type_i == REQ_WRITE && reg_select_i == SEL_RNR,
                   rnr_q == $past(write_data_i[RnrW-1:0]))

endmodule
